### rtl/i2cmts_pkg.sv
// ----------------------------------------------------------------------------
// i2cmts_pkg
// shared types and codes of the i2c master transfer sequencer
// ----------------------------------------------------------------------------
package i2cmts_pkg;

  localparam int TxDepthDefault = 16;

  // item kinds carried in the input tuser
  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_LOAD   = 2'd1,
    FUNC_STATUS = 2'd2
  } func_e;

  // transaction outcome as reported in result_code
  typedef enum logic [1:0] {
    OUT_NONE   = 2'd0,
    OUT_NACK   = 2'd1,
    OUT_BUSERR = 2'd2,
    OUT_DONE   = 2'd3
  } outcome_e;

  // controller status codes
  localparam logic [7:0] ST_BUS_ERR     = 8'h00;
  localparam logic [7:0] ST_START       = 8'h08;
  localparam logic [7:0] ST_RSTART      = 8'h10;
  localparam logic [7:0] ST_WADDR_ACK   = 8'h18;
  localparam logic [7:0] ST_WADDR_NACK  = 8'h20;
  localparam logic [7:0] ST_WDATA_ACK   = 8'h28;
  localparam logic [7:0] ST_WDATA_NACK  = 8'h30;
  localparam logic [7:0] ST_ARB_LOST    = 8'h38;
  localparam logic [7:0] ST_RADDR_ACK   = 8'h40;
  localparam logic [7:0] ST_RADDR_NACK  = 8'h48;
  localparam logic [7:0] ST_RDATA_ACK   = 8'h50;
  localparam logic [7:0] ST_RDATA_NACK  = 8'h58;

  localparam logic [7:0] ADDR_WR_MASK   = 8'hfe;

  // one result word before the buffer data is merged in
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_data;
    logic       use_mem;
    logic       set_start;
    logic       set_stop;
    logic       set_ack;
    logic       clear_ack;
    logic       clear_start;
    logic       clear_stop;
    logic       clear_int;
    logic       rx_valid;
    logic [7:0] rx_out;
    outcome_e   result;
  } res_t;

endpackage

### rtl/i2cmts_txbuf.sv
// ----------------------------------------------------------------------------
// i2cmts_txbuf
// transmit byte buffer, one write and one registered read port
// ----------------------------------------------------------------------------
module i2cmts_txbuf #(
  parameter int TX_DEPTH = 16,
  localparam int AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [TX_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/i2cmts_ctrl.sv
// ----------------------------------------------------------------------------
// i2cmts_ctrl
// transaction state and status decode, drives the buffer ports
// ----------------------------------------------------------------------------
module i2cmts_ctrl
  import i2cmts_pkg::*;
#(
  parameter int TX_DEPTH = 16,
  localparam int AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1,
  localparam int CW = $clog2(TX_DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [1:0]    func_i,
  input  logic [7:0]    dev_address_i,
  input  logic [4:0]    write_len_i,
  input  logic [7:0]    read_len_i,
  input  logic          read_request_i,
  input  logic [7:0]    tx_byte_i,
  input  logic [7:0]    status_code_i,
  input  logic [7:0]    rx_byte_i,
  output res_t          res_o,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output logic [7:0]    mem_wdata_o,
  output logic          mem_re_o,
  output logic [AW-1:0] mem_raddr_o
);

  localparam logic [CW-1:0] DepthC = CW'(TX_DEPTH);
  localparam logic [8:0]    Depth9 = 9'(TX_DEPTH);

  logic [CW-1:0] load_idx_q, load_idx_d;
  logic [CW-1:0] send_idx_q, send_idx_d;
  logic [4:0]    writes_left_q, writes_left_d;
  logic [7:0]    reads_left_q, reads_left_d;
  logic [7:0]    target_q, target_d;
  logic          rd_phase_q, rd_phase_d;
  outcome_e      outcome_q, outcome_d;

  logic          can_send;
  logic [4:0]    wl_min;
  logic [7:0]    rl_after;
  logic          re;
  res_t          res;

  assign can_send = (writes_left_q != 5'd0) && (send_idx_q < DepthC);
  assign wl_min   = (write_len_i == 5'd0) ? 5'd1 : write_len_i;
  // count left after this event takes a received byte
  assign rl_after = (reads_left_q != 8'd0) ? reads_left_q - 8'd1 : 8'd0;

  always_comb begin
    load_idx_d    = load_idx_q;
    send_idx_d    = send_idx_q;
    writes_left_d = writes_left_q;
    reads_left_d  = reads_left_q;
    target_d      = target_q;
    rd_phase_d    = rd_phase_q;
    outcome_d     = outcome_q;
    res           = '0;
    re            = 1'b0;
    mem_we_o      = 1'b0;

    unique case (func_i)
      FUNC_START: begin
        writes_left_d = ({4'b0, wl_min} > Depth9) ? Depth9[4:0] : wl_min;
        reads_left_d  = (read_len_i == 8'd0) ? 8'd1 : read_len_i;
        target_d      = dev_address_i & ADDR_WR_MASK;
        rd_phase_d    = read_request_i;
        load_idx_d    = '0;
        send_idx_d    = '0;
        outcome_d     = OUT_NONE;
        res.set_start = 1'b1;
      end
      FUNC_LOAD: begin
        if (load_idx_q < DepthC) begin
          mem_we_o   = 1'b1;
          load_idx_d = load_idx_q + 1'b1;
        end
      end
      FUNC_STATUS: begin
        unique case (status_code_i) inside
          ST_START, ST_RSTART: begin
            res.tx_valid    = 1'b1;
            res.tx_data     = target_q;
            res.clear_start = 1'b1;
            res.clear_int   = 1'b1;
          end
          ST_WADDR_ACK: begin
            res.tx_valid    = 1'b1;
            res.clear_start = 1'b1;
            res.clear_int   = 1'b1;
            if (can_send) begin
              re            = 1'b1;
              res.use_mem   = 1'b1;
              send_idx_d    = send_idx_q + 1'b1;
              writes_left_d = writes_left_q - 5'd1;
            end
          end
          ST_WADDR_NACK, ST_WDATA_NACK, ST_RADDR_NACK: begin
            outcome_d       = OUT_NACK;
            res.set_stop    = 1'b1;
            res.clear_start = 1'b1;
            res.clear_int   = 1'b1;
          end
          ST_WDATA_ACK: begin
            if (rd_phase_q && writes_left_q == 5'd0) begin
              // repeated start for the read phase
              target_d      = target_q | 8'h01;
              res.set_start = 1'b1;
              res.clear_int = 1'b1;
            end else if (writes_left_q != 5'd0) begin
              res.tx_valid    = 1'b1;
              res.clear_start = 1'b1;
              res.clear_int   = 1'b1;
              if (can_send) begin
                re            = 1'b1;
                res.use_mem   = 1'b1;
                send_idx_d    = send_idx_q + 1'b1;
                writes_left_d = writes_left_q - 5'd1;
              end
            end else begin
              outcome_d       = OUT_DONE;
              res.set_stop    = 1'b1;
              res.clear_start = 1'b1;
              res.clear_int   = 1'b1;
            end
          end
          ST_ARB_LOST: begin
            res.set_start  = 1'b1;
            res.clear_stop = 1'b1;
            res.clear_int  = 1'b1;
          end
          ST_RADDR_ACK: begin
            res.clear_ack   = (reads_left_q <= 8'd1);
            res.set_ack     = (reads_left_q > 8'd1);
            res.clear_start = 1'b1;
            res.clear_int   = 1'b1;
          end
          ST_RDATA_ACK: begin
            if (reads_left_q != 8'd0) begin
              res.rx_valid = 1'b1;
              res.rx_out   = rx_byte_i;
            end
            reads_left_d    = rl_after;
            res.clear_ack   = (rl_after <= 8'd1);
            res.set_ack     = (rl_after > 8'd1);
            res.clear_start = 1'b1;
            res.clear_int   = 1'b1;
          end
          ST_RDATA_NACK: begin
            if (reads_left_q != 8'd0) begin
              res.rx_valid = 1'b1;
              res.rx_out   = rx_byte_i;
            end
            reads_left_d    = rl_after;
            outcome_d       = OUT_DONE;
            res.set_stop    = 1'b1;
            res.clear_start = 1'b1;
            res.clear_int   = 1'b1;
          end
          ST_BUS_ERR: begin
            outcome_d       = OUT_BUSERR;
            res.set_stop    = 1'b1;
            res.clear_start = 1'b1;
            res.clear_int   = 1'b1;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    res.result = outcome_d;
    mem_we_o   = mem_we_o & accept_i;
  end

  assign mem_re_o    = re & accept_i;
  assign mem_raddr_o = send_idx_q[AW-1:0];
  assign mem_waddr_o = load_idx_q[AW-1:0];
  assign mem_wdata_o = tx_byte_i;
  assign res_o       = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_idx_q    <= '0;
      send_idx_q    <= '0;
      writes_left_q <= '0;
      reads_left_q  <= '0;
      target_q      <= '0;
      rd_phase_q    <= 1'b0;
      outcome_q     <= OUT_NONE;
    end else if (accept_i) begin
      load_idx_q    <= load_idx_d;
      send_idx_q    <= send_idx_d;
      writes_left_q <= writes_left_d;
      reads_left_q  <= reads_left_d;
      target_q      <= target_d;
      rd_phase_q    <= rd_phase_d;
      outcome_q     <= outcome_d;
    end
  end

endmodule

### rtl/i2c_master_transfer_sequencer_unit.sv
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer_unit
// sequences one i2c master write, optionally followed by a read, from status
// ----------------------------------------------------------------------------
// usage:
//   the input stream carries one word per item; tuser selects start, load or
//   status. a start word latches address, lengths and read flag, load words
//   fill the transmit buffer, status words from the byte-level controller
//   advance the transaction. every input word yields exactly one output word
//   with the controller actions, an optional received byte and the outcome.
// path: an accepted word is registered in stage one, and the transmit buffer
//   read is registered on accept alongside it; the read data is then merged
//   into the output register as the word leaves stage one.
// throughput: one word per cycle while the output is not stalled; the
//   transaction state is read, modified and written back on each accept.
// stall: a middle stage and the output register form a two-deep queue, so
//   one more word is taken while the output waits; with both full, tready
//   drops until the receiver takes the output word.
// reset: all counters, address and outcome clear, both stages empty; buffer
//   contents are undefined until loaded.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer_unit
  import i2cmts_pkg::*;
#(
  parameter int TX_DEPTH = TxDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // dev_address[7:0], write_len[12:8], read_len[20:13], read_request[21],
  // tx_byte[29:22], status_code[37:30], rx_byte[45:38], zero[47:46]
  input  logic [47:0] s_axis_tdata_i,
  // func[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tx_valid[0], tx_data[8:1], set_start[9], set_stop[10], set_ack[11],
  // clear_ack[12], clear_start[13], clear_stop[14], clear_int[15],
  // rx_valid[16], rx_out[24:17], result_code[26:25], zero[31:27]
  output logic [31:0] m_axis_tdata_o
);

  localparam int AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

  logic          accept;
  logic          advance;
  res_t          res;
  res_t          s1_q;
  logic          s1_valid_q, s1_valid_d;
  logic          out_valid_q, out_valid_d;
  logic [31:0]   out_q;
  logic [7:0]    tx_merged;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  assign advance         = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || advance;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  i2cmts_ctrl #(
    .TX_DEPTH(TX_DEPTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .func_i         (s_axis_tuser_i),
    .dev_address_i  (s_axis_tdata_i[7:0]),
    .write_len_i    (s_axis_tdata_i[12:8]),
    .read_len_i     (s_axis_tdata_i[20:13]),
    .read_request_i (s_axis_tdata_i[21]),
    .tx_byte_i      (s_axis_tdata_i[29:22]),
    .status_code_i  (s_axis_tdata_i[37:30]),
    .rx_byte_i      (s_axis_tdata_i[45:38]),
    .res_o          (res),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr)
  );

  i2cmts_txbuf #(
    .TX_DEPTH(TX_DEPTH)
  ) u_txbuf (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // buffer data only changes on accept, so it holds while stage one waits
  assign tx_merged = s1_q.use_mem ? mem_rdata : s1_q.tx_data;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= {5'b0, s1_q.result, s1_q.rx_out, s1_q.rx_valid,
                s1_q.clear_int, s1_q.clear_stop, s1_q.clear_start,
                s1_q.clear_ack, s1_q.set_ack, s1_q.set_stop, s1_q.set_start,
                tx_merged, s1_q.tx_valid};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  // an accepted word always lands in stage one
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted word not captured in stage one");

  // both stages full and receiver stalled: no new word may enter
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input taken while queue is full");

  // a stage-one word that waits keeps its buffer read data
  a_rdata_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> $stable(mem_rdata))
    else $error("buffer read data changed under a waiting word");

  // tx data is zero unless a byte is to be written
  a_txd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q[0]) |-> (out_q[8:1] == 8'd0))
    else $error("tx_data nonzero without tx_valid");

  // ack and nack are never asked for together
  a_ack_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q[11] && out_q[12]))
    else $error("set_ack and clear_ack both set");

endmodule
